// ===== sv/prlpd_pkg.sv =====
// ----------------------------------------------------------------------------
// prlpd_pkg
// Shared types and constants for the palette run-length pixel decoder.
// ----------------------------------------------------------------------------
package prlpd_pkg;

    localparam int PALETTE_ENTRIES_DEF = 8;
    localparam int HEADER_BYTES_DEF    = 16;
    localparam int QUEUE_DEPTH         = 2;

    localparam int BYTE_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;
    localparam int COORD_W    = 11;
    localparam int COLOR_W    = 16;
    localparam int INDEX_W    = 3;
    localparam int LEN_W      = 4;
    localparam int ENTRY_W    = 3;

    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MASK_MODE     = 3'd4;

    localparam logic [CFG_DATA_W-1:0] WINDOW_SIZE_RESET = 10'd20;

    // pair code: last pixel number when shown once or twice
    localparam logic [LEN_W-1:0] PAIR_LAST_ONCE  = 4'd1;
    localparam logic [LEN_W-1:0] PAIR_LAST_TWICE = 4'd3;

    localparam logic [INDEX_W-1:0] TRANSPARENT_INDEX = 3'd0;

    typedef enum logic {
        CMD_HEADER,
        CMD_PIXELS
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [BYTE_W-1:0]  data;
        logic [ENTRY_W-1:0] entry;
        logic               entry_ok;
        logic               high_half;
        logic               load_cursor;
        logic [LEN_W-1:0]   last_pix;
        logic [INDEX_W-1:0] idx_a;
        logic [INDEX_W-1:0] idx_b;
        logic               alternate;
    } cmd_t;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] origin_x;
        logic [CFG_DATA_W-1:0] origin_y;
        logic [CFG_DATA_W-1:0] window_width;
        logic [CFG_DATA_W-1:0] window_height;
        logic                  mask_mode;
    } cfg_t;

    typedef enum logic {
        BACK_IDLE,
        BACK_RUN
    } back_state_t;

endpackage

// ===== sv/prlpd_in_if.sv =====
// ----------------------------------------------------------------------------
// prlpd_in_if
// Byte stream channel: coded image bytes with end-of-image flag.
// ----------------------------------------------------------------------------
interface prlpd_in_if;
    logic                       valid;
    logic                       ready;
    logic [prlpd_pkg::BYTE_W-1:0] data_byte;
    logic                       end_of_image;

    modport source (output valid, output data_byte, output end_of_image, input ready);
    modport sink   (input valid, input data_byte, input end_of_image, output ready);
endinterface

// ===== sv/prlpd_out_if.sv =====
// ----------------------------------------------------------------------------
// prlpd_out_if
// Pixel channel: color, screen position and last-of-byte flag.
// ----------------------------------------------------------------------------
interface prlpd_out_if;
    logic                          valid;
    logic                          ready;
    logic [prlpd_pkg::COLOR_W-1:0] pixel_color;
    logic [prlpd_pkg::COORD_W-1:0] pixel_x;
    logic [prlpd_pkg::COORD_W-1:0] pixel_y;
    logic                          last_of_item;

    modport source (output valid, output pixel_color, output pixel_x, output pixel_y,
                    output last_of_item, input ready);
    modport sink   (input valid, input pixel_color, input pixel_x, input pixel_y,
                    input last_of_item, output ready);
endinterface

// ===== sv/prlpd_front.sv =====
// ----------------------------------------------------------------------------
// prlpd_front
// Accepts image bytes, tracks the header position and classifies each byte.
// ----------------------------------------------------------------------------
module prlpd_front #(
    parameter int PALETTE_ENTRIES = prlpd_pkg::PALETTE_ENTRIES_DEF,
    parameter int HEADER_BYTES    = prlpd_pkg::HEADER_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    prlpd_in_if.sink          image,
    input  logic              queue_full,
    output logic              push,
    output prlpd_pkg::cmd_t   cmd
);

    localparam int HC_W = $clog2(HEADER_BYTES + 1);

    logic [HC_W-1:0] hc_reg;
    logic [HC_W-1:0] hc_next;
    logic            in_header;

    assign image.ready = !queue_full;
    assign push        = image.valid && !queue_full;
    assign in_header   = hc_reg < HC_W'(HEADER_BYTES);

    always_comb
    begin
        cmd             = '0;
        cmd.data        = image.data_byte;
        cmd.entry       = prlpd_pkg::ENTRY_W'(hc_reg >> 1);
        cmd.entry_ok    = 32'(hc_reg >> 1) < PALETTE_ENTRIES;
        cmd.high_half   = !hc_reg[0];
        cmd.load_cursor = hc_reg == HC_W'(HEADER_BYTES - 1);
        cmd.idx_b       = image.data_byte[2:0];
        cmd.alternate   = !image.data_byte[7];
        if (in_header)
        begin
            cmd.kind = prlpd_pkg::CMD_HEADER;
        end
        else
        begin
            cmd.kind = prlpd_pkg::CMD_PIXELS;
        end
        if (image.data_byte[7])
        begin
            cmd.last_pix = image.data_byte[6:3];
            cmd.idx_a    = image.data_byte[2:0];
        end
        else
        begin
            cmd.last_pix = image.data_byte[3] ? prlpd_pkg::PAIR_LAST_TWICE
                                              : prlpd_pkg::PAIR_LAST_ONCE;
            cmd.idx_a    = image.data_byte[6:4];
        end
    end

    always_comb
    begin
        hc_next = hc_reg;
        if (push)
        begin
            if (in_header)
            begin
                hc_next = hc_reg + 1'b1;
            end
            if (image.end_of_image)
            begin
                hc_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hc_reg <= '0;
        end
        else
        begin
            hc_reg <= hc_next;
        end
    end

endmodule

// ===== sv/prlpd_queue.sv =====
// ----------------------------------------------------------------------------
// prlpd_queue
// Short command FIFO between the front and back parts.
// ----------------------------------------------------------------------------
module prlpd_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  prlpd_pkg::cmd_t push_cmd,
    input  logic            pop,
    output prlpd_pkg::cmd_t head,
    output logic            empty,
    output logic            full
);

    localparam int DEPTH = prlpd_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    prlpd_pkg::cmd_t  slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign empty   = count_reg == '0;
    assign full    = count_reg == CNT_W'(DEPTH);
    assign head    = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(DEPTH - 1))
        begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== sv/prlpd_back.sv =====
// ----------------------------------------------------------------------------
// prlpd_back
// Executes commands: palette loads, one cursor pixel per cycle unless stalled.
// ----------------------------------------------------------------------------
module prlpd_back #(
    parameter int PALETTE_ENTRIES = prlpd_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  prlpd_pkg::cfg_t cfg,
    input  prlpd_pkg::cmd_t head,
    input  logic            empty,
    output logic            pop,
    prlpd_out_if.source     pixels
);

    localparam int PIDX_W  = $clog2(PALETTE_ENTRIES);
    localparam int COLOR_W = prlpd_pkg::COLOR_W;
    localparam int COORD_W = prlpd_pkg::COORD_W;

    prlpd_pkg::back_state_t state_reg, state_next;

    logic [COLOR_W-1:0]          palette_reg [PALETTE_ENTRIES];
    prlpd_pkg::cmd_t             cmd_reg, cmd_next;
    logic [prlpd_pkg::LEN_W-1:0] k_reg, k_next;
    logic [COORD_W-1:0]          cx_reg, cx_next;
    logic [COORD_W-1:0]          cy_reg, cy_next;
    logic                        full_reg, full_next;
    logic                        pend_valid_reg, pend_valid_next;
    logic                        pend_done_reg, pend_done_next;
    logic [COLOR_W-1:0]          pend_color_reg, pend_color_next;
    logic [COORD_W-1:0]          pend_x_reg, pend_x_next;
    logic [COORD_W-1:0]          pend_y_reg, pend_y_next;
    logic                        out_valid_reg, out_valid_next;
    logic [COLOR_W-1:0]          out_color_reg, out_color_next;
    logic [COORD_W-1:0]          out_x_reg, out_x_next;
    logic [COORD_W-1:0]          out_y_reg, out_y_next;
    logic                        out_last_reg, out_last_next;

    logic                            running;
    logic [prlpd_pkg::INDEX_W-1:0]   idx;
    logic [COLOR_W-1:0]              color;
    logic                            last_pix;
    logic                            drop_all;
    logic                            emit;
    logic                            slot_free;
    logic                            step;
    logic                            move;
    logic                            take;
    logic                            take_hdr;
    logic [prlpd_pkg::CFG_DATA_W-1:0] w_eff;
    logic [prlpd_pkg::CFG_DATA_W-1:0] h_eff;
    logic [COORD_W-1:0]              x_end;
    logic [COORD_W-1:0]              y_end;
    logic [COORD_W-1:0]              cx_inc;
    logic [COORD_W-1:0]              cy_inc;

    assign running   = state_reg == prlpd_pkg::BACK_RUN;
    assign idx       = (cmd_reg.alternate && k_reg[0]) ? cmd_reg.idx_b : cmd_reg.idx_a;
    assign color     = (32'(idx) < PALETTE_ENTRIES) ? palette_reg[idx[PIDX_W-1:0]]
                                                    : '0;
    assign last_pix  = k_reg == cmd_reg.last_pix;
    assign drop_all  = cfg.mask_mode && full_reg;
    assign emit      = running && !drop_all
                       && !(cfg.mask_mode && idx == prlpd_pkg::TRANSPARENT_INDEX);
    assign slot_free = !out_valid_reg || pixels.ready;
    assign step      = running && !(emit && pend_valid_reg && !slot_free);
    assign move      = pend_valid_reg && slot_free && (pend_done_reg || (step && emit));
    assign take      = !empty && (!running || (step && last_pix));
    assign take_hdr  = take && head.kind == prlpd_pkg::CMD_HEADER;
    assign pop       = take;

    assign w_eff  = (cfg.window_width == '0) ? 10'd1 : cfg.window_width;
    assign h_eff  = (cfg.window_height == '0) ? 10'd1 : cfg.window_height;
    assign x_end  = {1'b0, cfg.origin_x} + {1'b0, w_eff};
    assign y_end  = {1'b0, cfg.origin_y} + {1'b0, h_eff};
    assign cx_inc = cx_reg + 1'b1;
    assign cy_inc = cy_reg + 1'b1;

    assign pixels.valid        = out_valid_reg;
    assign pixels.pixel_color  = out_color_reg;
    assign pixels.pixel_x      = out_x_reg;
    assign pixels.pixel_y      = out_y_reg;
    assign pixels.last_of_item = out_last_reg;

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        k_next          = k_reg;
        cx_next         = cx_reg;
        cy_next         = cy_reg;
        full_next       = full_reg;
        pend_valid_next = pend_valid_reg;
        pend_done_next  = pend_done_reg;
        pend_color_next = pend_color_reg;
        pend_x_next     = pend_x_reg;
        pend_y_next     = pend_y_reg;
        out_valid_next  = out_valid_reg;
        out_color_next  = out_color_reg;
        out_x_next      = out_x_reg;
        out_y_next      = out_y_reg;
        out_last_next   = out_last_reg;

        unique case (state_reg)
            prlpd_pkg::BACK_IDLE:
            begin
                if (take && !take_hdr)
                begin
                    state_next = prlpd_pkg::BACK_RUN;
                end
            end
            prlpd_pkg::BACK_RUN:
            begin
                if (step && last_pix && !(take && !take_hdr))
                begin
                    state_next = prlpd_pkg::BACK_IDLE;
                end
            end
            default:
            begin
                state_next = prlpd_pkg::BACK_IDLE;
            end
        endcase

        if (step)
        begin
            k_next = k_reg + 1'b1;
        end
        if (take && !take_hdr)
        begin
            cmd_next = head;
            k_next   = '0;
        end

        if (step && !drop_all)
        begin
            if (cx_inc >= x_end)
            begin
                cx_next = {1'b0, cfg.origin_x};
                if (cy_inc >= y_end)
                begin
                    if (cfg.mask_mode)
                    begin
                        full_next = 1'b1;
                        cy_next   = cy_inc;
                    end
                    else
                    begin
                        cy_next = {1'b0, cfg.origin_y};
                    end
                end
                else
                begin
                    cy_next = cy_inc;
                end
            end
            else
            begin
                cx_next = cx_inc;
            end
        end
        if (take_hdr && head.load_cursor)
        begin
            cx_next   = {1'b0, cfg.origin_x};
            cy_next   = {1'b0, cfg.origin_y};
            full_next = 1'b0;
        end

        if (step && emit)
        begin
            pend_valid_next = 1'b1;
            pend_done_next  = last_pix;
            pend_color_next = color;
            pend_x_next     = cx_reg;
            pend_y_next     = cy_reg;
        end
        else if (move)
        begin
            pend_valid_next = 1'b0;
            pend_done_next  = 1'b0;
        end
        else if (step && last_pix && pend_valid_reg)
        begin
            pend_done_next = 1'b1;
        end

        if (move)
        begin
            out_valid_next = 1'b1;
            out_color_next = pend_color_reg;
            out_x_next     = pend_x_reg;
            out_y_next     = pend_y_reg;
            out_last_next  = pend_done_reg;
        end
        else if (pixels.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_hdr && head.entry_ok)
        begin
            if (head.high_half)
            begin
                palette_reg[head.entry[PIDX_W-1:0]][15:8] <= head.data;
            end
            else
            begin
                palette_reg[head.entry[PIDX_W-1:0]][7:0] <= head.data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= prlpd_pkg::BACK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg          <= '0;
            cx_reg         <= '0;
            cy_reg         <= '0;
            full_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            pend_done_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            k_reg          <= k_next;
            cx_reg         <= cx_next;
            cy_reg         <= cy_next;
            full_reg       <= full_next;
            pend_valid_reg <= pend_valid_next;
            pend_done_reg  <= pend_done_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        pend_color_reg <= pend_color_next;
        pend_x_reg     <= pend_x_next;
        pend_y_reg     <= pend_y_next;
        out_color_reg  <= out_color_next;
        out_x_reg      <= out_x_next;
        out_y_reg      <= out_y_next;
        out_last_reg   <= out_last_next;
    end

endmodule

// ===== sv/palette_run_length_pixel_decoder.sv =====
// ----------------------------------------------------------------------------
// palette_run_length_pixel_decoder
// Palette-based run-length image decoder producing positioned pixels.
// ----------------------------------------------------------------------------
//  channel   dir  handshake     payload
//  image     in   valid/ready   data_byte[7:0], end_of_image
//  pixels    out  valid/ready   pixel_color[15:0], pixel_x[10:0], pixel_y[10:0],
//                               last_of_item
//  cfg_*     in   cfg_we        cfg_index[2:0], cfg_data[9:0]
//
//  A pixel byte covers 1 to 16 pixels; a header byte loads palette data. The
//  back end's pixel loop sets the rate; the front accepts a byte per cycle
//  while the two-entry command queue has room.
//  Each pixel is held one stage until the next one shows whether it is last.
//  No clearing pass after reset. A stalled pixel output holds the back end.
// ----------------------------------------------------------------------------
module palette_run_length_pixel_decoder #(
    parameter int PALETTE_ENTRIES = prlpd_pkg::PALETTE_ENTRIES_DEF,
    parameter int HEADER_BYTES    = prlpd_pkg::HEADER_BYTES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    prlpd_in_if.sink                            image,
    prlpd_out_if.source                         pixels,
    input  logic                                cfg_we,
    input  logic [prlpd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [prlpd_pkg::CFG_DATA_W-1:0]    cfg_data
);

    prlpd_pkg::cfg_t cfg_reg, cfg_next;
    prlpd_pkg::cmd_t push_cmd;
    prlpd_pkg::cmd_t head;
    logic            push;
    logic            pop;
    logic            empty;
    logic            full;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                prlpd_pkg::REG_ORIGIN_X:      cfg_next.origin_x      = cfg_data;
                prlpd_pkg::REG_ORIGIN_Y:      cfg_next.origin_y      = cfg_data;
                prlpd_pkg::REG_WINDOW_WIDTH:  cfg_next.window_width  = cfg_data;
                prlpd_pkg::REG_WINDOW_HEIGHT: cfg_next.window_height = cfg_data;
                prlpd_pkg::REG_MASK_MODE:     cfg_next.mask_mode     = cfg_data[0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin_x      <= '0;
            cfg_reg.origin_y      <= '0;
            cfg_reg.window_width  <= prlpd_pkg::WINDOW_SIZE_RESET;
            cfg_reg.window_height <= prlpd_pkg::WINDOW_SIZE_RESET;
            cfg_reg.mask_mode     <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    prlpd_front #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES),
        .HEADER_BYTES    (HEADER_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .image      (image),
        .queue_full (full),
        .push       (push),
        .cmd        (push_cmd)
    );

    prlpd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .empty    (empty),
        .full     (full)
    );

    prlpd_back #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .head   (head),
        .empty  (empty),
        .pop    (pop),
        .pixels (pixels)
    );

endmodule

// ===== tb/palette_run_length_pixel_decoder_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_run_length_pixel_decoder_test
// Drives coded image bytes through the decoder and compares every pixel
// transaction against a local palette/cursor model: a directed image first,
// then random images over a series of window and mask settings, with random
// sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module palette_run_length_pixel_decoder_test;

    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 24;
    localparam int DRAIN_CYCLES    = 64;
    localparam int N_DIRECTED      = 25;

    typedef struct packed {
        logic [prlpd_pkg::COLOR_W-1:0] color;
        logic [prlpd_pkg::COORD_W-1:0] x;
        logic [prlpd_pkg::COORD_W-1:0] y;
        logic                          last;
    } pixel_t;

    typedef enum logic [1:0] {
        CHK_PREDICT,
        CHK_NONE,
        CHK_ONE
    } row_check_t;

    typedef struct packed {
        logic [prlpd_pkg::BYTE_W-1:0]  b;
        logic                          eoi;
        row_check_t                    chk;
        logic [prlpd_pkg::COLOR_W-1:0] color;
        logic [prlpd_pkg::COORD_W-1:0] x;
        logic [prlpd_pkg::COORD_W-1:0] y;
    } row_t;

    // palette 0000 FFFF 1234 A5C3 8001 7FFE 00FF FF00, default 20x20 window
    localparam row_t DIRECTED [N_DIRECTED] = '{
        '{8'h00, 1'b0, CHK_NONE, 16'h0000, 11'd0, 11'd0},
        '{8'h00, 1'b0, CHK_NONE, 16'h0000, 11'd0, 11'd0},
        '{8'hFF, 1'b0, CHK_NONE, 16'h0000, 11'd0, 11'd0},
        '{8'hFF, 1'b0, CHK_NONE, 16'h0000, 11'd0, 11'd0},
        '{8'h12, 1'b0, CHK_NONE, 16'h0000, 11'd0, 11'd0},
        '{8'h34, 1'b0, CHK_NONE, 16'h0000, 11'd0, 11'd0},
        '{8'hA5, 1'b0, CHK_NONE, 16'h0000, 11'd0, 11'd0},
        '{8'hC3, 1'b0, CHK_NONE, 16'h0000, 11'd0, 11'd0},
        '{8'h80, 1'b0, CHK_NONE, 16'h0000, 11'd0, 11'd0},
        '{8'h01, 1'b0, CHK_NONE, 16'h0000, 11'd0, 11'd0},
        '{8'h7F, 1'b0, CHK_NONE, 16'h0000, 11'd0, 11'd0},
        '{8'hFE, 1'b0, CHK_NONE, 16'h0000, 11'd0, 11'd0},
        '{8'h00, 1'b0, CHK_NONE, 16'h0000, 11'd0, 11'd0},
        '{8'hFF, 1'b0, CHK_NONE, 16'h0000, 11'd0, 11'd0},
        '{8'hFF, 1'b0, CHK_NONE, 16'h0000, 11'd0, 11'd0},
        '{8'h00, 1'b0, CHK_NONE, 16'h0000, 11'd0, 11'd0},
        '{8'h80, 1'b0, CHK_ONE,  16'h0000, 11'd0, 11'd0},
        '{8'h81, 1'b0, CHK_ONE,  16'hFFFF, 11'd1, 11'd0},
        '{8'h87, 1'b0, CHK_ONE,  16'hFF00, 11'd2, 11'd0},
        '{8'hFF, 1'b0, CHK_PREDICT, 16'h0000, 11'd0, 11'd0},
        '{8'h00, 1'b0, CHK_PREDICT, 16'h0000, 11'd0, 11'd0},
        '{8'h7F, 1'b0, CHK_PREDICT, 16'h0000, 11'd0, 11'd0},
        '{8'h3A, 1'b0, CHK_PREDICT, 16'h0000, 11'd0, 11'd0},
        '{8'h85, 1'b1, CHK_PREDICT, 16'h0000, 11'd0, 11'd0},
        '{8'h5A, 1'b1, CHK_NONE, 16'h0000, 11'd0, 11'd0}
    };

    // window extremes: single pixel, full range with mask, zero size,
    // mask with a small window that fills up, zero width with mask
    localparam prlpd_pkg::cfg_t FIXED_WINDOWS [5] = '{
        '{10'd0,    10'd0,    10'd1,    10'd1,    1'b0},
        '{10'd1023, 10'd1023, 10'd1023, 10'd1023, 1'b1},
        '{10'd5,    10'd7,    10'd0,    10'd0,    1'b0},
        '{10'd10,   10'd3,    10'd3,    10'd2,    1'b1},
        '{10'd100,  10'd200,  10'd0,    10'd5,    1'b1}
    };

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_we;
    logic [prlpd_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [prlpd_pkg::CFG_DATA_W-1:0] cfg_data;

    prlpd_in_if  image_ch ();
    prlpd_out_if pixel_ch ();

    palette_run_length_pixel_decoder u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .image     (image_ch),
        .pixels    (pixel_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // decoder model state
    prlpd_pkg::cfg_t cfg = '{10'd0, 10'd0, prlpd_pkg::WINDOW_SIZE_RESET,
                             prlpd_pkg::WINDOW_SIZE_RESET, 1'b0};
    logic [prlpd_pkg::COLOR_W-1:0] pal [prlpd_pkg::PALETTE_ENTRIES_DEF];
    int unsigned                   hdr_taken = 0;
    logic [prlpd_pkg::COORD_W-1:0] cur_x = '0;
    logic [prlpd_pkg::COORD_W-1:0] cur_y = '0;
    bit                            win_full = 1'b0;

    pixel_t expected_pixels [$];
    pixel_t byte_pixels [$];
    int     mismatches = 0;
    int     burst_left = 0;
    bit     gaps_on = 1'b1;
    int     stall_pct = 20;
    int     ready_hold = 0;

    always #5 clk = ~clk;

    function automatic void step_cursor();
        int unsigned w;
        int unsigned h;
        int unsigned ox;
        int unsigned oy;
        w  = (cfg.window_width == '0) ? 1 : cfg.window_width;
        h  = (cfg.window_height == '0) ? 1 : cfg.window_height;
        ox = cfg.origin_x;
        oy = cfg.origin_y;
        cur_x = cur_x + 11'd1;
        if (cur_x >= ox + w)
        begin
            cur_x = 11'(ox);
            cur_y = cur_y + 11'd1;
            if (cur_y >= oy + h)
            begin
                if (cfg.mask_mode)
                    win_full = 1'b1;
                else
                    cur_y = 11'(oy);
            end
        end
    endfunction

    function automatic void place_pixel(input logic [prlpd_pkg::INDEX_W-1:0] idx);
        pixel_t p;
        if (cfg.mask_mode && win_full)
            return;
        if (!(cfg.mask_mode && idx == prlpd_pkg::TRANSPARENT_INDEX))
        begin
            p.color = pal[idx];
            p.x     = cur_x;
            p.y     = cur_y;
            p.last  = 1'b0;
            byte_pixels.push_back(p);
        end
        step_cursor();
    endfunction

    function automatic void decode_byte(input logic [prlpd_pkg::BYTE_W-1:0] b,
                                        input logic eoi, input bit keep);
        int n;
        byte_pixels.delete();
        if (hdr_taken < prlpd_pkg::HEADER_BYTES_DEF)
        begin
            if (hdr_taken[0] == 1'b0)
                pal[hdr_taken >> 1][15:8] = b;
            else
                pal[hdr_taken >> 1][7:0] = b;
            hdr_taken++;
            if (hdr_taken >= prlpd_pkg::HEADER_BYTES_DEF)
            begin
                cur_x    = 11'(cfg.origin_x);
                cur_y    = 11'(cfg.origin_y);
                win_full = 1'b0;
            end
        end
        else if (b[7])
        begin
            for (int k = 0; k <= int'(b[6:3]); k++)
                place_pixel(b[2:0]);
        end
        else
        begin
            for (int k = 0; k < (b[3] ? 2 : 1); k++)
            begin
                place_pixel(b[6:4]);
                place_pixel(b[2:0]);
            end
        end
        if (eoi)
            hdr_taken = 0;
        n = byte_pixels.size();
        if (n > 0)
            byte_pixels[n-1].last = 1'b1;
        if (keep)
            foreach (byte_pixels[i])
                expected_pixels.push_back(byte_pixels[i]);
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
            mismatches++;
        end
    endfunction

    task automatic send_byte(input logic [prlpd_pkg::BYTE_W-1:0] b, input logic eoi);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = gaps_on ? $urandom_range(0, 6) : 0;
            if (gap > 0)
            begin
                image_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        image_ch.valid        <= 1'b1;
        image_ch.data_byte    <= b;
        image_ch.end_of_image <= eoi;
        @(posedge clk);
        while (!image_ch.ready)
            @(posedge clk);
    endtask

    task automatic stop_and_drain();
        image_ch.valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [prlpd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [prlpd_pkg::CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic write_window(input prlpd_pkg::cfg_t win);
        write_reg(prlpd_pkg::REG_ORIGIN_X, win.origin_x);
        write_reg(prlpd_pkg::REG_ORIGIN_Y, win.origin_y);
        write_reg(prlpd_pkg::REG_WINDOW_WIDTH, win.window_width);
        write_reg(prlpd_pkg::REG_WINDOW_HEIGHT, win.window_height);
        // upper bits of the mask write are don't-care
        write_reg(prlpd_pkg::REG_MASK_MODE, {9'($urandom_range(0, 511)), win.mask_mode});
        cfg = win;
    endtask

    always @(posedge clk)
    begin
        if (ready_hold == 0)
        begin
            ready_hold = $urandom_range(1, 8);
            pixel_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
        else
            ready_hold--;
    end

    always @(posedge clk)
    begin : pixel_check
        pixel_t got;
        pixel_t want;
        if (rst_n && pixel_ch.valid && pixel_ch.ready)
        begin
            got = '{pixel_ch.pixel_color, pixel_ch.pixel_x, pixel_ch.pixel_y,
                    pixel_ch.last_of_item};
            if (expected_pixels.size() == 0)
            begin
                $display("%0t ns: unexpected pixel transaction, expected none, actual %p",
                         $time, got);
                mismatches++;
            end
            else
            begin
                want = expected_pixels.pop_front();
                check_field("pixel_color", want.color, got.color);
                check_field("pixel_x", want.x, got.x);
                check_field("pixel_y", want.y, got.y);
                check_field("last_of_item", want.last, got.last);
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        prlpd_pkg::cfg_t win;
        logic [7:0]      b;
        logic            eoi;
        pixel_t          typed;
        clk                   = 1'b0;
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = '0;
        cfg_data              = '0;
        image_ch.valid        = 1'b0;
        image_ch.data_byte    = '0;
        image_ch.end_of_image = 1'b0;
        pixel_ch.ready        = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
        begin
            send_byte(DIRECTED[i].b, DIRECTED[i].eoi);
            decode_byte(DIRECTED[i].b, DIRECTED[i].eoi, DIRECTED[i].chk == CHK_PREDICT);
            if (DIRECTED[i].chk == CHK_ONE)
            begin
                typed = '{DIRECTED[i].color, DIRECTED[i].x, DIRECTED[i].y, 1'b1};
                expected_pixels.push_back(typed);
            end
        end
        stop_and_drain();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph < 5)
                win = FIXED_WINDOWS[ph];
            else
            begin
                win.origin_x      = 10'($urandom_range(0, 1023));
                win.origin_y      = 10'($urandom_range(0, 1023));
                win.window_width  = 10'($urandom_range(1, 40));
                win.window_height = 10'($urandom_range(1, 12));
                win.mask_mode     = 1'($urandom_range(0, 1));
            end
            write_window(win);
            stall_pct = (ph % 4 == 0) ? 0 : (ph % 4 == 1) ? 30 : (ph % 4 == 2) ? 60 : 10;
            gaps_on   = (ph % 3 != 0);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                b = 8'($urandom_range(0, 255));
                if (hdr_taken < prlpd_pkg::HEADER_BYTES_DEF)
                    eoi = ($urandom_range(0, 39) == 0);
                else
                    eoi = ($urandom_range(0, 19) == 0);
                // even phases close the image so the next window starts clean
                if (n == ITEMS_PER_PHASE - 1 && ph % 2 == 0)
                    eoi = 1'b1;
                send_byte(b, eoi);
                decode_byte(b, eoi, 1'b1);
                if ($urandom_range(0, 29) == 0)
                    stop_and_drain();
            end
            stop_and_drain();
        end

        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== palette_run_length_pixel_decoder.f =====
sv/prlpd_pkg.sv
sv/prlpd_in_if.sv
sv/prlpd_out_if.sv
sv/prlpd_front.sv
sv/prlpd_queue.sv
sv/prlpd_back.sv
sv/palette_run_length_pixel_decoder.sv
tb/palette_run_length_pixel_decoder_test.sv
